@@ hw/rtl/assert_macros.svh @@
// shared assertion helpers, clocked on clk and muted while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/b2y_pkg.sv @@
package b2y_pkg;

	// default frame limits
	localparam int unsigned MAX_WIDTH_DEF  = 4096;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;

	// register file
	localparam int unsigned CFG_DATA_W  = 13;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned RESET_WIDTH  = 640;
	localparam int unsigned RESET_HEIGHT = 480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_CHROMA_ORDER = 2'd2
	} cfg_reg_t;

	localparam logic CHROMA_NV12 = 1'b0;
	localparam logic CHROMA_NV21 = 1'b1;

	// field widths
	localparam int unsigned PIX_W         = 8;
	localparam int unsigned LUMA_ADDR_W   = 24;
	localparam int unsigned CHROMA_ADDR_W = 25;

	// queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// bt.601 studio range arithmetic, all sums fit in 18 signed bits
	localparam int unsigned SUM_W = 18;
	localparam logic signed [SUM_W-1:0] COEF_YR = 18'sd66;
	localparam logic signed [SUM_W-1:0] COEF_YG = 18'sd129;
	localparam logic signed [SUM_W-1:0] COEF_YB = 18'sd25;
	localparam logic signed [SUM_W-1:0] COEF_UR = 18'sd38;
	localparam logic signed [SUM_W-1:0] COEF_UG = 18'sd74;
	localparam logic signed [SUM_W-1:0] COEF_UB = 18'sd112;
	localparam logic signed [SUM_W-1:0] COEF_VR = 18'sd112;
	localparam logic signed [SUM_W-1:0] COEF_VG = 18'sd94;
	localparam logic signed [SUM_W-1:0] COEF_VB = 18'sd18;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = 18'sd128;
	localparam logic signed [SUM_W-1:0] CHROMA_OFS = 18'sd32768;
	localparam logic signed [SUM_W-1:0] LUMA_OFS   = 18'sd16;
	localparam logic signed [SUM_W-1:0] PIX_MAX    = 18'sd255;
	localparam int unsigned FRAC_BITS = 8;

	// one classified pixel on its way to the back end
	typedef struct packed {
		logic [PIX_W-1:0]         blue;
		logic [PIX_W-1:0]         green;
		logic [PIX_W-1:0]         red;
		logic [LUMA_ADDR_W-1:0]   luma_address;
		logic                     chroma_valid;
		logic [CHROMA_ADDR_W-1:0] chroma_address;
		logic                     end_of_frame;
		logic                     chroma_order;
	} item_t;

	// saturate a signed sum to one byte
	function automatic logic [PIX_W-1:0] clamp8(input logic signed [SUM_W-1:0] v);
		logic [PIX_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > PIX_MAX) begin
			r = PIX_W'(PIX_MAX);
		end else begin
			r = v[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/bgr_to_yuv420_semiplanar_core.sv @@
// an accepted input passes through the queue, the stage-1 register and the output register
// throughput: one pixel per clock while out_ready holds, set by the position counters
//   in the front end and the two-stage constant-multiply pipeline in the back end
// a four-entry queue decouples the two, so input keeps flowing while a result waits
// reset (arst_n low, asynchronous): 640 x 480, nv12 order, frame start, pipeline and queue empty
// no clearing pass: the block takes pixels as soon as reset is released
module bgr_to_yuv420_semiplanar_core #(
	parameter int unsigned MAX_WIDTH  = b2y_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = b2y_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port, no read-back
	input  logic                                cfg_we,
	input  logic [b2y_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [b2y_pkg::CFG_DATA_W-1:0]      cfg_data,
	// pixel input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [b2y_pkg::PIX_W-1:0]           blue,
	input  logic [b2y_pkg::PIX_W-1:0]           green,
	input  logic [b2y_pkg::PIX_W-1:0]           red,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [b2y_pkg::PIX_W-1:0]           luma,
	output logic [b2y_pkg::LUMA_ADDR_W-1:0]     luma_address,
	output logic                                chroma_valid,
	output logic [b2y_pkg::PIX_W-1:0]           first_chroma,
	output logic [b2y_pkg::PIX_W-1:0]           second_chroma,
	output logic [b2y_pkg::CHROMA_ADDR_W-1:0]   chroma_address,
	output logic                                end_of_frame
);

	// front to queue
	logic           push;
	logic           push_ready;
	b2y_pkg::item_t push_item;

	// queue to back
	logic           pop;
	logic           pop_valid;
	b2y_pkg::item_t pop_item;

	// front end: frame geometry, raster counters, luma and chroma addresses,
	// tags each pixel with its chroma flag and end of frame
	b2y_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.push        (push),
		.push_item   (push_item),
		.queue_ready (push_ready)
	);

	// short queue of classified pixels
	b2y_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid)
	);

	// back end: color math, clamping, chroma order and the output register
	b2y_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (pop_valid),
		.item           (pop_item),
		.take           (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.luma           (luma),
		.luma_address   (luma_address),
		.chroma_valid   (chroma_valid),
		.first_chroma   (first_chroma),
		.second_chroma  (second_chroma),
		.chroma_address (chroma_address),
		.end_of_frame   (end_of_frame)
	);

endmodule

@@ hw/rtl/b2y_front.sv @@
`include "assert_macros.svh"

module b2y_front #(
	parameter int unsigned MAX_WIDTH  = b2y_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = b2y_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [b2y_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [b2y_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [b2y_pkg::PIX_W-1:0]        blue,
	input  logic [b2y_pkg::PIX_W-1:0]        green,
	input  logic [b2y_pkg::PIX_W-1:0]        red,
	output logic                             push,
	output b2y_pkg::item_t                   push_item,
	input  logic                             queue_ready
);

	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned RW   = $clog2(MAX_HEIGHT);
	localparam int unsigned PW   = WW + HW;
	localparam int unsigned CAW  = b2y_pkg::CHROMA_ADDR_W;
	localparam int unsigned EXTW = (PW > CAW) ? PW : CAW;
	localparam int unsigned RESET_W =
		(b2y_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : b2y_pkg::RESET_WIDTH;
	localparam int unsigned RESET_H =
		(b2y_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : b2y_pkg::RESET_HEIGHT;

	logic [WW-1:0]                         eff_w_q;
	logic [HW-1:0]                         eff_h_q;
	logic                                  order_q;
	logic [CW-1:0]                         col_q;
	logic [RW-1:0]                         row_q;
	logic [b2y_pkg::LUMA_ADDR_W-1:0]       luma_pos_q;
	logic [CAW-1:0]                        chroma_pos_q;
	logic                                  reload_q;

	logic                                  accept;
	logic [WW:0]                           col_plus;
	logic [HW:0]                           row_plus;
	logic                                  col_last;
	logic                                  row_last;
	logic                                  eof;
	logic                                  cvalid;
	logic [PW-1:0]                         frame_prod;
	logic [EXTW-1:0]                       frame_ext;
	logic [CAW-1:0]                        cur_chroma;
	logic                                  col_in_range;

	// 0 reads as 1, anything above the limit reads as the limit
	function automatic logic [31:0] clamp_dim(input logic [b2y_pkg::CFG_DATA_W-1:0] v,
			input int unsigned lim);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 == 32'd0) begin
			return 32'd1;
		end else if (v32 > lim) begin
			return lim;
		end
		return v32;
	endfunction

	assign in_ready = queue_ready;
	assign accept   = in_valid && queue_ready;
	assign push     = accept;

	assign col_plus = (WW+1)'(col_q) + (WW+1)'(1);
	assign row_plus = (HW+1)'(row_q) + (HW+1)'(1);
	assign col_last = col_plus >= {1'b0, eff_w_q};
	assign row_last = row_plus >= {1'b0, eff_h_q};
	assign eof      = col_last && row_last;
	assign cvalid   = !col_q[0] && !row_q[0];

	// chroma plane start, used right after a restart
	assign frame_prod = PW'(eff_w_q) * PW'(eff_h_q);
	assign frame_ext  = EXTW'(frame_prod);
	assign cur_chroma = reload_q ? frame_ext[CAW-1:0] : chroma_pos_q;

	always_comb begin
		push_item.blue           = blue;
		push_item.green          = green;
		push_item.red            = red;
		push_item.luma_address   = luma_pos_q;
		push_item.chroma_valid   = cvalid;
		push_item.chroma_address = cvalid ? cur_chroma : '0;
		push_item.end_of_frame   = eof;
		push_item.chroma_order   = order_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q      <= WW'(RESET_W);
			eff_h_q      <= HW'(RESET_H);
			order_q      <= b2y_pkg::CHROMA_NV12;
			col_q        <= '0;
			row_q        <= '0;
			luma_pos_q   <= '0;
			chroma_pos_q <= '0;
			reload_q     <= 1'b1;
		end else begin
			if (accept) begin
				reload_q     <= 1'b0;
				chroma_pos_q <= cvalid ? cur_chroma + CAW'(2) : cur_chroma;
				if (eof) begin
					col_q      <= '0;
					row_q      <= '0;
					luma_pos_q <= '0;
					reload_q   <= 1'b1;
				end else begin
					luma_pos_q <= luma_pos_q + b2y_pkg::LUMA_ADDR_W'(1);
					if (col_last) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
			if (cfg_we) begin
				unique case (b2y_pkg::cfg_reg_t'(cfg_index))
					b2y_pkg::REG_IMAGE_WIDTH: begin
						eff_w_q    <= WW'(clamp_dim(cfg_data, MAX_WIDTH));
						col_q      <= '0;
						row_q      <= '0;
						luma_pos_q <= '0;
						reload_q   <= 1'b1;
					end
					b2y_pkg::REG_IMAGE_HEIGHT: begin
						eff_h_q    <= HW'(clamp_dim(cfg_data, MAX_HEIGHT));
						col_q      <= '0;
						row_q      <= '0;
						luma_pos_q <= '0;
						reload_q   <= 1'b1;
					end
					b2y_pkg::REG_CHROMA_ORDER: begin
						order_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign col_in_range = WW'(col_q) < eff_w_q;

	`ASSERT_CLK(a_col_in_frame, col_in_range, "column counter beyond frame width")
	`ASSERT_CLK(a_restart_has_chroma, (accept && reload_q) |-> push_item.chroma_valid,
		"first pixel of a frame without chroma")

endmodule

@@ hw/rtl/b2y_queue.sv @@
`include "assert_macros.svh"

module b2y_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b2y_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output b2y_pkg::item_t pop_item,
	output logic           pop_valid
);

	localparam int unsigned DEPTH = b2y_pkg::QUEUE_DEPTH;
	localparam int unsigned PTRW  = $clog2(DEPTH);
	localparam int unsigned CNTW  = $clog2(DEPTH + 1);

	b2y_pkg::item_t   mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign push_ready = count_q != CNTW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_underflow, pop && !pop_valid, "pop from empty queue")
	`ASSERT_NEVER(a_no_overflow, push && !push_ready, "push into full queue")

endmodule

@@ hw/rtl/b2y_back.sv @@
module b2y_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  b2y_pkg::item_t                      item,
	output logic                                take,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [b2y_pkg::PIX_W-1:0]           luma,
	output logic [b2y_pkg::LUMA_ADDR_W-1:0]     luma_address,
	output logic                                chroma_valid,
	output logic [b2y_pkg::PIX_W-1:0]           first_chroma,
	output logic [b2y_pkg::PIX_W-1:0]           second_chroma,
	output logic [b2y_pkg::CHROMA_ADDR_W-1:0]   chroma_address,
	output logic                                end_of_frame
);

	localparam int unsigned SW = b2y_pkg::SUM_W;
	localparam int unsigned PW = b2y_pkg::PIX_W;

	logic                  valid_s1;
	logic signed [SW-1:0]  y_s1;
	logic signed [SW-1:0]  u_s1;
	logic signed [SW-1:0]  v_s1;
	b2y_pkg::item_t        meta_s1;

	logic                  out_valid_q;
	logic [PW-1:0]         luma_q;
	logic [b2y_pkg::LUMA_ADDR_W-1:0]   luma_addr_q;
	logic                  cvalid_q;
	logic [PW-1:0]         first_q;
	logic [PW-1:0]         second_q;
	logic [b2y_pkg::CHROMA_ADDR_W-1:0] caddr_q;
	logic                  eof_q;

	logic                  adv_out;
	logic                  s1_ready;
	logic signed [SW-1:0]  b_s;
	logic signed [SW-1:0]  g_s;
	logic signed [SW-1:0]  r_s;
	logic signed [SW-1:0]  y_sum;
	logic signed [SW-1:0]  u_sum;
	logic signed [SW-1:0]  v_sum;
	logic [PW-1:0]         y_c;
	logic [PW-1:0]         u_c;
	logic [PW-1:0]         v_c;

	assign adv_out  = !out_valid_q || out_ready;
	assign s1_ready = !valid_s1 || adv_out;
	assign take     = item_valid && s1_ready;

	// stage 1: constant multiplies, bias keeps chroma sums non-negative
	assign b_s = $signed(SW'(item.blue));
	assign g_s = $signed(SW'(item.green));
	assign r_s = $signed(SW'(item.red));

	assign y_sum = b2y_pkg::COEF_YR * r_s + b2y_pkg::COEF_YG * g_s
		+ b2y_pkg::COEF_YB * b_s + b2y_pkg::ROUND_BIAS;
	assign u_sum = b2y_pkg::COEF_UB * b_s - b2y_pkg::COEF_UR * r_s
		- b2y_pkg::COEF_UG * g_s + b2y_pkg::ROUND_BIAS + b2y_pkg::CHROMA_OFS;
	assign v_sum = b2y_pkg::COEF_VR * r_s - b2y_pkg::COEF_VG * g_s
		- b2y_pkg::COEF_VB * b_s + b2y_pkg::ROUND_BIAS + b2y_pkg::CHROMA_OFS;

	// stage 2: floor shift, offset, saturate
	assign y_c = b2y_pkg::clamp8((y_s1 >>> b2y_pkg::FRAC_BITS) + b2y_pkg::LUMA_OFS);
	assign u_c = b2y_pkg::clamp8(u_s1 >>> b2y_pkg::FRAC_BITS);
	assign v_c = b2y_pkg::clamp8(v_s1 >>> b2y_pkg::FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			y_s1    <= y_sum;
			u_s1    <= u_sum;
			v_s1    <= v_sum;
			meta_s1 <= item;
		end
		if (valid_s1 && adv_out) begin
			luma_q      <= y_c;
			luma_addr_q <= meta_s1.luma_address;
			cvalid_q    <= meta_s1.chroma_valid;
			caddr_q     <= meta_s1.chroma_address;
			eof_q       <= meta_s1.end_of_frame;
			if (!meta_s1.chroma_valid) begin
				first_q  <= '0;
				second_q <= '0;
			end else if (meta_s1.chroma_order == b2y_pkg::CHROMA_NV21) begin
				first_q  <= v_c;
				second_q <= u_c;
			end else begin
				first_q  <= u_c;
				second_q <= v_c;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign luma           = luma_q;
	assign luma_address   = luma_addr_q;
	assign chroma_valid   = cvalid_q;
	assign first_chroma   = first_q;
	assign second_chroma  = second_q;
	assign chroma_address = caddr_q;
	assign end_of_frame   = eof_q;

endmodule

@@ test/bgr_to_yuv420_semiplanar_core_tb.sv @@
`timescale 1ns / 1ps

module bgr_to_yuv420_semiplanar_core_tb;

	// pipeline allowance that settle waits out once nothing is pending
	localparam int PIPE_LATENCY = 2;
	// cycles without any accepted transaction before the run is given up
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	// the index field has room for one register more than the block has
	localparam logic [b2y_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [b2y_pkg::CFG_DATA_W-1:0] CFG_ALL_ONES = '1;

	// how the two channels hold back during a phase
	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_mode_t;

	typedef struct packed {
		logic [b2y_pkg::PIX_W-1:0] blue;
		logic [b2y_pkg::PIX_W-1:0] green;
		logic [b2y_pkg::PIX_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [b2y_pkg::PIX_W-1:0]         luma;
		logic [b2y_pkg::LUMA_ADDR_W-1:0]   luma_address;
		logic                              chroma_valid;
		logic [b2y_pkg::PIX_W-1:0]         first_chroma;
		logic [b2y_pkg::PIX_W-1:0]         second_chroma;
		logic [b2y_pkg::CHROMA_ADDR_W-1:0] chroma_address;
		logic                              end_of_frame;
	} nv_sample_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [b2y_pkg::CFG_INDEX_W-1:0]   cfg_index;
	logic [b2y_pkg::CFG_DATA_W-1:0]    cfg_data;
	logic                              in_valid;
	logic                              in_ready;
	logic [b2y_pkg::PIX_W-1:0]         blue;
	logic [b2y_pkg::PIX_W-1:0]         green;
	logic [b2y_pkg::PIX_W-1:0]         red;
	logic                              out_valid;
	logic                              out_ready;
	logic [b2y_pkg::PIX_W-1:0]         luma;
	logic [b2y_pkg::LUMA_ADDR_W-1:0]   luma_address;
	logic                              chroma_valid;
	logic [b2y_pkg::PIX_W-1:0]         first_chroma;
	logic [b2y_pkg::PIX_W-1:0]         second_chroma;
	logic [b2y_pkg::CHROMA_ADDR_W-1:0] chroma_address;
	logic                              end_of_frame;

	// pixels waiting for the driver, and conversions waiting for the monitor
	pixel_t     pixel_backlog[$];
	nv_sample_t nv_expected[$];

	flow_mode_t flow_mode;
	logic       pixel_taken;
	pixel_t     next_pixel;
	int         mismatches;
	int         quiet_cycles;

	// shadow of the register file and the frame position counters
	logic [b2y_pkg::CFG_DATA_W-1:0]    frame_width;
	logic [b2y_pkg::CFG_DATA_W-1:0]    frame_height;
	logic                              chroma_swap;
	logic [11:0]                       col_pos;
	logic [11:0]                       row_pos;
	logic [b2y_pkg::LUMA_ADDR_W-1:0]   luma_pos;
	logic [b2y_pkg::CHROMA_ADDR_W-1:0] chroma_pos;

	bgr_to_yuv420_semiplanar_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.blue           (blue),
		.green          (green),
		.red            (red),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.luma           (luma),
		.luma_address   (luma_address),
		.chroma_valid   (chroma_valid),
		.first_chroma   (first_chroma),
		.second_chroma  (second_chroma),
		.chroma_address (chroma_address),
		.end_of_frame   (end_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// zero becomes one, anything past the limit is held at the limit
	function automatic logic [b2y_pkg::CFG_DATA_W-1:0] clip_dim(
		input logic [b2y_pkg::CFG_DATA_W-1:0] v, input int unsigned limit);
		if (v == '0) begin
			return b2y_pkg::CFG_DATA_W'(1);
		end else if (int'(v) > int'(limit)) begin
			return b2y_pkg::CFG_DATA_W'(limit);
		end
		return v;
	endfunction

	function automatic logic [b2y_pkg::PIX_W-1:0] to_byte(input int v);
		if (v < 0) begin
			return '0;
		end else if (v > 255) begin
			return 8'd255;
		end
		return v[b2y_pkg::PIX_W-1:0];
	endfunction

	// append one pixel to the driver backlog
	function automatic void enqueue_pixel(input pixel_t p);
		pixel_backlog = {pixel_backlog, p};
	endfunction

	// back to the top left pixel; chroma plane starts right after the luma plane
	function automatic void restart_frame();
		int w;
		int h;
		w = int'(clip_dim(frame_width, b2y_pkg::MAX_WIDTH_DEF));
		h = int'(clip_dim(frame_height, b2y_pkg::MAX_HEIGHT_DEF));
		col_pos = '0;
		row_pos = '0;
		luma_pos = '0;
		chroma_pos = b2y_pkg::CHROMA_ADDR_W'(w * h);
	endfunction

	function automatic void reset_shadow();
		frame_width = b2y_pkg::CFG_DATA_W'(b2y_pkg::RESET_WIDTH);
		frame_height = b2y_pkg::CFG_DATA_W'(b2y_pkg::RESET_HEIGHT);
		chroma_swap = b2y_pkg::CHROMA_NV12;
		restart_frame();
	endfunction

	function automatic void apply_register(input logic [b2y_pkg::CFG_INDEX_W-1:0] idx,
		input logic [b2y_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			b2y_pkg::REG_IMAGE_WIDTH: begin
				frame_width = value;
				restart_frame();
			end
			b2y_pkg::REG_IMAGE_HEIGHT: begin
				frame_height = value;
				restart_frame();
			end
			// order switch applies from the next pixel, frame keeps going
			b2y_pkg::REG_CHROMA_ORDER: begin
				chroma_swap = value[0];
			end
			default: begin
			end
		endcase
	endfunction

	// bt.601 studio range conversion of one pixel, advances the frame position
	function automatic nv_sample_t convert_pixel(input pixel_t p);
		int         y_val;
		int         u_val;
		int         v_val;
		int         w;
		int         h;
		logic       row_done;
		logic       frame_done;
		nv_sample_t r;
		w = int'(clip_dim(frame_width, b2y_pkg::MAX_WIDTH_DEF));
		h = int'(clip_dim(frame_height, b2y_pkg::MAX_HEIGHT_DEF));
		y_val = ((66 * int'(p.red) + 129 * int'(p.green) + 25 * int'(p.blue) + 128) >>> 8) + 16;
		u_val = (-38 * int'(p.red) - 74 * int'(p.green) + 112 * int'(p.blue) + 128 + 32768) >>> 8;
		v_val = (112 * int'(p.red) - 94 * int'(p.green) - 18 * int'(p.blue) + 128 + 32768) >>> 8;
		row_done = (int'(col_pos) + 1 >= w);
		frame_done = row_done && (int'(row_pos) + 1 >= h);
		r.luma = to_byte(y_val);
		r.luma_address = luma_pos;
		r.chroma_valid = !row_pos[0] && !col_pos[0];
		if (r.chroma_valid) begin
			r.first_chroma = chroma_swap ? to_byte(v_val) : to_byte(u_val);
			r.second_chroma = chroma_swap ? to_byte(u_val) : to_byte(v_val);
			r.chroma_address = chroma_pos;
			chroma_pos = chroma_pos + b2y_pkg::CHROMA_ADDR_W'(2);
		end else begin
			r.first_chroma = '0;
			r.second_chroma = '0;
			r.chroma_address = '0;
		end
		r.end_of_frame = frame_done;
		if (frame_done) begin
			restart_frame();
		end else begin
			luma_pos = luma_pos + b2y_pkg::LUMA_ADDR_W'(1);
			if (row_done) begin
				col_pos = '0;
				row_pos = row_pos + 12'd1;
			end else begin
				col_pos = col_pos + 12'd1;
			end
		end
		return r;
	endfunction

	function automatic logic sender_rests();
		case (flow_mode)
			FLOW_SENDER_GAPS: return $urandom_range(99) < 76;
			FLOW_BOTH:        return $urandom_range(99) < 6;
			default:          return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_rests();
		case (flow_mode)
			FLOW_RECEIVER_STALLS: return $urandom_range(99) < 76;
			FLOW_BOTH:            return $urandom_range(99) < 6;
			default:              return 1'b0;
		endcase
	endfunction

	// components lean toward black and full scale, the rest uniform
	function automatic logic [b2y_pkg::PIX_W-1:0] random_component();
		case ($urandom_range(9))
			0:       return '0;
			1:       return 8'd255;
			default: return b2y_pkg::PIX_W'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.blue = random_component();
		p.green = random_component();
		p.red = random_component();
		return p;
	endfunction

	// driver: new pixel only when the channel is empty or the last transaction went through
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || pixel_taken) begin
				if (pixel_backlog.size() != 0 && !sender_rests()) begin
					next_pixel = pixel_backlog.pop_front();
					blue <= next_pixel.blue;
					green <= next_pixel.green;
					red <= next_pixel.red;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !receiver_rests();
		end
	end

	// monitor: tracks register writes, predicts accepted pixels, checks results in order
	always @(posedge clk) begin
		nv_sample_t seen;
		nv_sample_t want;
		nv_sample_t pred;
		if (!arst_n) begin
			reset_shadow();
			pixel_taken <= 1'b0;
			quiet_cycles = 0;
		end else begin
			pixel_taken <= in_valid && in_ready;
			if (cfg_we) begin
				apply_register(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				pred = convert_pixel('{blue, green, red});
				nv_expected = {nv_expected, pred};
			end
			if (out_valid && out_ready) begin
				seen = '{luma, luma_address, chroma_valid, first_chroma, second_chroma,
					chroma_address, end_of_frame};
				if (nv_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("%0t: result transaction with nothing pending: y %0d at %0d",
							$realtime, seen.luma, seen.luma_address);
					end
				end else begin
					want = nv_expected.pop_front();
					if (seen.luma !== want.luma || seen.luma_address !== want.luma_address ||
						seen.chroma_valid !== want.chroma_valid ||
						seen.first_chroma !== want.first_chroma ||
						seen.second_chroma !== want.second_chroma ||
						seen.chroma_address !== want.chroma_address ||
						seen.end_of_frame !== want.end_of_frame) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: mismatch y/yaddr/cv/c0/c1/caddr/eof", $realtime);
							$display("  expected %0d %0d %0b %0d %0d %0d %0b", want.luma,
								want.luma_address, want.chroma_valid, want.first_chroma,
								want.second_chroma, want.chroma_address, want.end_of_frame);
							$display("  actual   %0d %0d %0b %0d %0d %0d %0b", seen.luma,
								seen.luma_address, seen.chroma_valid, seen.first_chroma,
								seen.second_chroma, seen.chroma_address, seen.end_of_frame);
						end
					end
				end
			end
			// watchdog on channel activity
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// one register write, enable dropped on the following falling edge
	task automatic write_register(input logic [b2y_pkg::CFG_INDEX_W-1:0] idx,
		input logic [b2y_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// block idle: nothing queued, nothing in flight, pipeline drained
	task automatic settle();
		while (pixel_backlog.size() != 0 || in_valid || nv_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic run_phase(input logic [b2y_pkg::CFG_DATA_W-1:0] w,
		input logic [b2y_pkg::CFG_DATA_W-1:0] h,
		input logic order, input flow_mode_t mode, input int count);
		settle();
		write_register(b2y_pkg::REG_IMAGE_WIDTH, w);
		write_register(b2y_pkg::REG_IMAGE_HEIGHT, h);
		write_register(b2y_pkg::REG_CHROMA_ORDER, b2y_pkg::CFG_DATA_W'(order));
		flow_mode = mode;
		repeat (count) enqueue_pixel(random_pixel());
	endtask

	initial begin
		pixel_t corner_pixels[12];
		int     phase_width[13];
		int     phase_height[13];
		int     phase_count[13];
		corner_pixels = '{
			'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
			'{8'd0, 8'd0, 8'd255}, '{8'd0, 8'd255, 8'd0},
			'{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd255},
			'{8'd255, 8'd255, 8'd0}, '{8'd255, 8'd0, 8'd255},
			'{8'd128, 8'd128, 8'd128}, '{8'd1, 8'd2, 8'd4},
			'{8'd170, 8'd85, 8'd170}, '{8'd85, 8'd170, 8'd85}
		};
		// tiny frames wrap often, wide and tall ones check the plane offsets
		phase_width  = '{2, 3, 4, 5, 1, 9, 16, 7, 4096, 8191, 2, 33, 640};
		phase_height = '{2, 5, 4, 3, 7, 1, 9, 6, 4096, 2, 8191, 4, 480};
		phase_count  = '{60, 90, 100, 100, 60, 60, 150, 120, 40, 40, 40, 150, 40};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = b2y_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		blue = '0;
		green = '0;
		red = '0;
		flow_mode = FLOW_FREE;
		mismatches = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// primaries and corners on the reset frame size
		foreach (corner_pixels[k]) enqueue_pixel(corner_pixels[k]);

		// order switch mid frame, position keeps counting
		settle();
		write_register(b2y_pkg::REG_CHROMA_ORDER, b2y_pkg::CFG_DATA_W'(b2y_pkg::CHROMA_NV21));
		repeat (4) enqueue_pixel(random_pixel());

		// write to the spare index must leave the frame alone
		settle();
		write_register(REG_UNUSED, CFG_ALL_ONES);
		repeat (2) enqueue_pixel(random_pixel());

		// zero sizes behave as a single pixel frame
		settle();
		write_register(b2y_pkg::REG_IMAGE_WIDTH, '0);
		write_register(b2y_pkg::REG_IMAGE_HEIGHT, '0);
		repeat (3) enqueue_pixel(random_pixel());

		// oversize values clip to the largest frame
		settle();
		write_register(b2y_pkg::REG_IMAGE_WIDTH, CFG_ALL_ONES);
		write_register(b2y_pkg::REG_IMAGE_HEIGHT, CFG_ALL_ONES);
		repeat (2) enqueue_pixel(random_pixel());

		// random pixels over a spread of frame shapes, orders and flow modes
		for (int i = 0; i < 13; i++) begin
			run_phase(b2y_pkg::CFG_DATA_W'(phase_width[i]),
				b2y_pkg::CFG_DATA_W'(phase_height[i]),
				(i % 2 == 1) ? b2y_pkg::CHROMA_NV21 : b2y_pkg::CHROMA_NV12,
				flow_mode_t'(i % 4), phase_count[i]);
		end

		settle();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
